>>> sv/esd_pkg.sv
// shared types, constants and decode helpers for the escape sequence decoder
// no dependencies; imported by every module of the block
package esd_pkg;

    // maximum number of octal digits in one escape (1 to 3)
    localparam int MAX_OCTAL_DIGITS = 3;
    localparam logic [2:0] MAX_OCT_W = 3'(MAX_OCTAL_DIGITS);

    // result queue between the decode and output sides
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_ESC  = 3'd1,
        MODE_OCT  = 3'd2,
        MODE_HEX0 = 3'd3,
        MODE_HEX1 = 3'd4,
        MODE_DROP = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_BAD_HEX = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
        logic       last;
    } res_t;

    // one queue entry holds all results caused by one input transfer
    typedef struct packed {
        logic two;
        res_t r1;
        res_t r0;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // octal digit: {valid, value}
    function automatic logic [3:0] oct_val(input logic [7:0] b);
        oct_val = (b >= 8'h30 && b <= 8'h37) ? {1'b1, b[2:0]} : 4'b0;
    endfunction

    // hex digit: {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        v = 5'b0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            v = {1'b1, 4'(b[3:0] + 4'd9)};
        end
        return v;
    endfunction

    // named escapes: {found, value}
    function automatic logic [8:0] named_lookup(input logic [7:0] b);
        logic [8:0] v;
        case (b)
            8'h6e:   v = {1'b1, 8'd10};
            8'h74:   v = {1'b1, 8'd9};
            8'h76:   v = {1'b1, 8'd11};
            8'h62:   v = {1'b1, 8'd8};
            8'h72:   v = {1'b1, 8'd13};
            8'h66:   v = {1'b1, 8'd12};
            8'h61:   v = {1'b1, 8'd7};
            8'h5c:   v = {1'b1, 8'd92};
            8'h3f:   v = {1'b1, 8'd63};
            8'h27:   v = {1'b1, 8'd39};
            8'h22:   v = {1'b1, 8'd34};
            default: v = 9'b0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/esd_front.sv
// decode side: accepts raw bytes, tracks the escape state and builds one
// queue entry of up to two results per transfer; uses esd_pkg
module esd_front
    import esd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    input  logic       last_byte,
    output logic       push,
    output q_entry_t   entry
);

    mode_t      mode_reg, mode_next, mid_mode;
    logic [8:0] dv_reg, dv_next, mid_dv;
    logic [1:0] dc_reg, dc_next, mid_dc;

    logic [3:0] ov;
    logic [4:0] hv;
    logic [8:0] nl;
    logic [2:0] dc_inc;

    res_t       res [2];
    logic [1:0] n;
    logic       fresh;
    logic       bad_hex;

    assign ov     = oct_val(in_byte);
    assign hv     = hex_val(in_byte);
    assign nl     = named_lookup(in_byte);
    assign dc_inc = {1'b0, dc_reg} + 3'd1;

    // state after the byte itself, before a closing last byte
    always_comb begin
        mid_mode = MODE_IDLE;
        mid_dv   = '0;
        mid_dc   = '0;
        fresh    = 1'b0;
        case (mode_reg)
            MODE_DROP: begin
                mid_mode = MODE_DROP;
            end
            MODE_OCT: begin
                if (ov[3]) begin
                    if (dc_inc < MAX_OCT_W) begin
                        mid_mode = MODE_OCT;
                        mid_dv   = {dv_reg[5:0], ov[2:0]};
                        mid_dc   = dc_inc[1:0];
                    end
                end else begin
                    fresh = 1'b1;
                end
            end
            MODE_HEX1: begin
                fresh = !hv[4];
            end
            MODE_HEX0: begin
                if (hv[4]) begin
                    mid_mode = MODE_HEX1;
                    mid_dv   = {5'b0, hv[3:0]};
                end else begin
                    mid_mode = MODE_DROP;
                end
            end
            MODE_ESC: begin
                if (ov[3]) begin
                    if (MAX_OCT_W > 3'd1) begin
                        mid_mode = MODE_OCT;
                        mid_dv   = {6'b0, ov[2:0]};
                        mid_dc   = 2'd1;
                    end
                end else if (in_byte == CH_LOW_X || in_byte == CH_UP_X) begin
                    mid_mode = MODE_HEX0;
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase
        if (fresh && in_byte == CH_BSLASH) begin
            mid_mode = MODE_ESC;
        end
    end

    // next state: a last byte always leaves the decoder idle
    always_comb begin
        if (last_byte) begin
            mode_next = MODE_IDLE;
            dv_next   = '0;
            dc_next   = '0;
        end else begin
            mode_next = mid_mode;
            dv_next   = mid_dv;
            dc_next   = mid_dc;
        end
    end

    // results caused by this byte
    always_comb begin
        res[0]  = '{data: 8'h00, status: ST_OK, last: 1'b0};
        res[1]  = '{data: 8'h00, status: ST_OK, last: 1'b0};
        n       = 2'd0;
        bad_hex = 1'b0;
        case (mode_reg)
            MODE_DROP: begin
                n = 2'd0;
            end
            MODE_OCT: begin
                if (ov[3]) begin
                    if (dc_inc >= MAX_OCT_W) begin
                        res[0].data = {dv_reg[4:0], ov[2:0]};
                        n = 2'd1;
                    end
                end else begin
                    res[0].data = dv_reg[7:0];
                    n = 2'd1;
                end
            end
            MODE_HEX1: begin
                res[0].data = hv[4] ? {dv_reg[3:0], hv[3:0]} : dv_reg[7:0];
                n = 2'd1;
            end
            MODE_HEX0: begin
                if (!hv[4]) begin
                    res[0].status = ST_BAD_HEX;
                    n = 2'd1;
                    bad_hex = 1'b1;
                end
            end
            MODE_ESC: begin
                if (ov[3]) begin
                    if (MAX_OCT_W <= 3'd1) begin
                        res[0].data = {5'b0, ov[2:0]};
                        n = 2'd1;
                    end
                end else if (in_byte != CH_LOW_X && in_byte != CH_UP_X) begin
                    res[0].data   = nl[8] ? nl[7:0] : in_byte;
                    res[0].status = nl[8] ? ST_OK : ST_UNKNOWN;
                    n = 2'd1;
                end
            end
            default: begin
                n = 2'd0;
            end
        endcase
        // plain byte copied through
        if (fresh && in_byte != CH_BSLASH) begin
            res[n[0]].data   = in_byte;
            res[n[0]].status = ST_OK;
            n = n + 2'd1;
        end
        // an escape still open at the last byte is closed here
        if (last_byte && !bad_hex && mode_reg != MODE_DROP) begin
            case (mid_mode)
                MODE_ESC: begin
                    res[n[0]].data   = 8'h00;
                    res[n[0]].status = ST_UNKNOWN;
                    n = n + 2'd1;
                end
                MODE_OCT, MODE_HEX1: begin
                    res[n[0]].data   = mid_dv[7:0];
                    res[n[0]].status = ST_OK;
                    n = n + 2'd1;
                end
                MODE_HEX0: begin
                    res[n[0]].data   = 8'h00;
                    res[n[0]].status = ST_BAD_HEX;
                    n = n + 2'd1;
                end
                default: begin
                end
            endcase
        end
        // mark the final result of the literal
        if ((last_byte || bad_hex) && n != 2'd0) begin
            if (n == 2'd2) begin
                res[1].last = 1'b1;
            end else begin
                res[0].last = 1'b1;
            end
        end
    end

    assign push      = in_accept && (n != 2'd0);
    assign entry.two = (n == 2'd2);
    assign entry.r0  = res[0];
    assign entry.r1  = res[1];

    // decode state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            dv_reg   <= '0;
            dc_reg   <= '0;
        end else if (in_accept) begin
            mode_reg <= mode_next;
            dv_reg   <= dv_next;
            dc_reg   <= dc_next;
        end
    end

`ifndef SYNTHESIS
    // a rejected hex escape always ends the literal's output
    a_bad_hex_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push && entry.r0.status == ST_BAD_HEX |-> entry.r0.last && !entry.two)
        else $error("bad hex result not marked last");

    // the drop mode is left only on a last byte
    a_drop_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_DROP && in_accept && !last_byte |=> mode_reg == MODE_DROP)
        else $error("drop mode left early");
`endif

endmodule

>>> sv/esd_fifo.sv
// short queue of result entries between the decode and output sides
// uses esd_pkg for the entry type and depth
module esd_fifo
    import esd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output q_entry_t head,
    output q_stat_t  stat
);

    q_entry_t       mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg, count_next;
    logic           do_push, do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (QAW+1)'(QDEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QAW+1)'(QDEPTH))
        else $error("queue fill level out of range");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push lost");
`endif

endmodule

>>> sv/esd_back.sv
// output side: takes entries from the queue and sends their results one
// per transfer through an output register; uses esd_pkg
module esd_back
    import esd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  q_entry_t head,
    input  q_stat_t  stat,
    output logic     pop,
    input  logic     m_ready,
    output logic     m_valid,
    output res_t     m_res
);

    logic phase_reg, phase_next;
    logic valid_reg;
    res_t res_reg;
    logic load;

    assign load    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    // a two-result entry is popped only when its second result is loaded
    always_comb begin
        pop        = 1'b0;
        phase_next = phase_reg;
        if (load && !stat.empty) begin
            if (!phase_reg && head.two) begin
                phase_next = 1'b1;
            end else begin
                pop        = 1'b1;
                phase_next = 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (load) begin
                valid_reg <= !stat.empty;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !stat.empty) begin
            res_reg <= phase_reg ? head.r1 : head.r0;
        end
    end

`ifndef SYNTHESIS
    a_phase_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> !stat.empty && head.two)
        else $error("second result pending without a two-result entry");
`endif

endmodule

>>> sv/escape_sequence_decoder.sv
// top level of the escape sequence decoder: decode side, result queue and
// output side; depends on esd_pkg, esd_front, esd_fifo and esd_back
//
//  port group   dir  contents
//  s_*          in   raw body byte (tdata), end of literal (tlast)
//  m_*          out  decoded byte (tdata), status (tuser), final result (tlast)
//
// one input transfer per cycle while the queue is not full; each byte gives
// zero, one or two results; results leave one per cycle while m_tready is high,
// so two-result bytes fill the four-entry queue and stall the input only when
// it is full; aresetn is synchronous and clears the decode state, queue and
// output valid; either side may stall freely; the queue decouples the two
module escape_sequence_decoder
    import esd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] status
    output logic       m_tlast
);

    q_entry_t entry, head;
    q_stat_t  stat;
    logic     push, pop, in_accept;
    res_t     m_res;

    assign s_tready  = !stat.full;
    assign in_accept = s_tvalid && s_tready;

    esd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .last_byte (s_tlast),
        .push      (push),
        .entry     (entry)
    );

    esd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (entry),
        .pop        (pop),
        .head       (head),
        .stat       (stat)
    );

    esd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .stat    (stat),
        .pop     (pop),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .m_res   (m_res)
    );

    assign m_tdata = m_res.data;
    assign m_tuser = m_res.status;
    assign m_tlast = m_res.last;

endmodule

>>> test/escape_sequence_decoder_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for escape_sequence_decoder: random and directed literal bodies,
// results checked against an in-bench decode of every accepted byte
// depends on esd_pkg and escape_sequence_decoder
module escape_sequence_decoder_tb
    import esd_pkg::*;
;

    localparam int STALL_LIMIT  = 1000;
    localparam int BODY_TARGET  = 1300;
    localparam int CALM_FIRST   = 500;
    localparam int CALM_END     = 800;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 100;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [7:0] chr;
        logic       tail;
    } body_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic [1:0] m_tuser;           // [1:0] status
    logic       m_tlast;

    body_byte_t body_queue[$];
    res_t       expected_results[$];
    res_t       step_out[$];

    // decoder state mirrored in the bench
    mode_t      dec_mode = MODE_IDLE;
    logic [8:0] acc_value = '0;
    logic [1:0] acc_digits = '0;

    int body_total = 0;
    int body_taken = 0;
    int fed_cnt = 0;
    int drained_cnt = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;
    int errors = 0;

    escape_sequence_decoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // character classes
    function automatic int octal_digit(input logic [7:0] c);
        if (c >= "0" && c <= "7") return int'(c) - 48;
        return -1;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        return -1;
    endfunction

    function automatic int named_code(input logic [7:0] c);
        case (c)
            "n":     return 10;
            "t":     return 9;
            "v":     return 11;
            "b":     return 8;
            "r":     return 13;
            "f":     return 12;
            "a":     return 7;
            "\\":    return 92;
            "?":     return 63;
            "'":     return 39;
            "\"":    return 34;
            default: return -1;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'(48 + v);
        return ($urandom_range(0, 1) != 0) ? 8'(55 + v) : 8'(87 + v);
    endfunction

    task automatic emit(input logic [7:0] data, input status_t st);
        res_t r;
        r.data = data;
        r.status = st;
        r.last = 1'b0;
        step_out.push_back(r);
    endtask

    task automatic clear_escape();
        dec_mode = MODE_IDLE;
        acc_value = '0;
        acc_digits = '0;
    endtask

    // decode one accepted body byte into its expected results
    task automatic decode_body_byte(input logic [7:0] c, input logic tail);
        int   d;
        logic reparse;
        res_t r;
        reparse = 1'b0;
        step_out.delete();
        case (dec_mode)
            MODE_DROP: begin
                if (tail) clear_escape();
                return;
            end
            MODE_OCT: begin
                d = octal_digit(c);
                if (d >= 0) begin
                    acc_value = {acc_value[5:0], 3'(d)};
                    acc_digits = acc_digits + 2'd1;
                    if (int'(acc_digits) >= MAX_OCTAL_DIGITS) begin
                        emit(acc_value[7:0], ST_OK);
                        clear_escape();
                    end
                end else begin
                    emit(acc_value[7:0], ST_OK);
                    clear_escape();
                    reparse = 1'b1;
                end
            end
            MODE_HEX1: begin
                d = hex_digit(c);
                if (d >= 0) begin
                    emit({acc_value[3:0], 4'(d)}, ST_OK);
                    clear_escape();
                end else begin
                    emit(acc_value[7:0], ST_OK);
                    clear_escape();
                    reparse = 1'b1;
                end
            end
            MODE_HEX0: begin
                d = hex_digit(c);
                if (d >= 0) begin
                    acc_value = 9'(d);
                    dec_mode = MODE_HEX1;
                end else begin
                    // rejected hex escape ends the literal, rest is dropped
                    r.data = 8'h00;
                    r.status = ST_BAD_HEX;
                    r.last = 1'b1;
                    expected_results.push_back(r);
                    clear_escape();
                    if (!tail) dec_mode = MODE_DROP;
                    return;
                end
            end
            MODE_ESC: begin
                d = octal_digit(c);
                if (d >= 0) begin
                    acc_value = 9'(d);
                    acc_digits = 2'd1;
                    if (MAX_OCTAL_DIGITS <= 1) begin
                        emit(acc_value[7:0], ST_OK);
                        clear_escape();
                    end else begin
                        dec_mode = MODE_OCT;
                    end
                end else if (c == CH_LOW_X || c == CH_UP_X) begin
                    acc_value = '0;
                    dec_mode = MODE_HEX0;
                end else begin
                    d = named_code(c);
                    if (d >= 0) emit(8'(d), ST_OK);
                    else emit(c, ST_UNKNOWN);
                    clear_escape();
                end
            end
            default: begin
                clear_escape();
                reparse = 1'b1;
            end
        endcase

        // the byte that closed an escape is decoded on its own
        if (reparse) begin
            if (c == CH_BSLASH) dec_mode = MODE_ESC;
            else emit(c, ST_OK);
        end

        // close whatever is still open at the end of the literal
        if (tail) begin
            case (dec_mode)
                MODE_ESC:  emit(8'h00, ST_UNKNOWN);
                MODE_OCT:  emit(acc_value[7:0], ST_OK);
                MODE_HEX1: emit(acc_value[7:0], ST_OK);
                MODE_HEX0: emit(8'h00, ST_BAD_HEX);
                default: ;
            endcase
            clear_escape();
            if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
        end
        foreach (step_out[i]) expected_results.push_back(step_out[i]);
    endtask

    task automatic add_byte(input logic [7:0] c, input logic tail);
        body_byte_t e;
        e.chr = c;
        e.tail = tail;
        body_queue.push_back(e);
    endtask

    task automatic add_text(input string s, input bit tail);
        for (int i = 0; i < s.len(); i++) add_byte(s[i], tail && (i == s.len() - 1));
    endtask

    // one literal built from plain bytes and escapes of every kind
    task automatic add_literal();
        int         pieces;
        int         kind;
        int         n;
        logic [7:0] c;
        string      names;
        names = "ntvbrfa\\?'\"";
        pieces = $urandom_range(1, 8);
        for (int p = 0; p < pieces; p++) begin
            kind = $urandom_range(0, 39);
            if (kind < 14) begin
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (kind < 20) begin
                add_byte(CH_BSLASH, 1'b0);
                add_byte(names[$urandom_range(0, 10)], 1'b0);
            end else if (kind < 26) begin
                add_byte(CH_BSLASH, 1'b0);
                n = $urandom_range(1, 3);
                repeat (n) add_byte(8'(48 + $urandom_range(0, 7)), 1'b0);
            end else if (kind < 32) begin
                add_byte(CH_BSLASH, 1'b0);
                add_byte(($urandom_range(0, 1) != 0) ? CH_LOW_X : CH_UP_X, 1'b0);
                n = $urandom_range(1, 2);
                repeat (n) add_byte(hex_char($urandom_range(0, 15)), 1'b0);
            end else if (kind < 36) begin
                do c = 8'($urandom_range(0, 255));
                while (octal_digit(c) >= 0 || c == CH_LOW_X || c == CH_UP_X || named_code(c) >= 0);
                add_byte(CH_BSLASH, 1'b0);
                add_byte(c, 1'b0);
            end else if (kind < 38) begin
                do c = 8'($urandom_range(0, 255));
                while (hex_digit(c) >= 0);
                add_byte(CH_BSLASH, 1'b0);
                add_byte(CH_LOW_X, 1'b0);
                add_byte(c, 1'b0);
            end else if (p == pieces - 1) begin
                add_byte(CH_BSLASH, 1'b0);
            end else begin
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        body_queue[body_queue.size() - 1].tail = 1'b1;
    endtask

    // stimulus, reset and end of run
    initial begin
        // directed literals
        add_byte(8'hff, 1'b0);
        add_byte(8'h00, 1'b1);
        add_text("\\777\\12z", 1'b1);
        add_text("\\xFf", 1'b1);
        add_text("\\x5\\n", 1'b1);
        add_text("\\xgqr", 1'b1);
        add_text("\\xg", 1'b1);
        add_text("\\x", 1'b1);
        add_text("\\", 1'b1);
        add_text("\\q", 1'b1);

        // random literals with some unstructured noise
        while (body_queue.size() < BODY_TARGET) begin
            if ($urandom_range(0, 4) != 0) begin
                add_literal();
            end else begin
                repeat ($urandom_range(1, 10))
                    add_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
                body_queue[body_queue.size() - 1].tail = 1'b1;
            end
        end
        body_total = body_queue.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (body_taken < body_total) @(negedge aclk);
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (errors == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // input driver: random gaps except in a calm stretch
    always @(posedge aclk) begin : drive
        body_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (body_queue.size() != 0 &&
                ((fed_cnt >= CALM_FIRST && fed_cnt < CALM_END) || $urandom_range(0, 99) >= 16)) begin
                nxt = body_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.chr;
                s_tlast  <= nxt.tail;
                fed_cnt++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink: random stalls, one long hold-off, a calm stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) drained_cnt++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && drained_cnt >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (drained_cnt >= CALM_FIRST && drained_cnt < CALM_END) ||
                            ($urandom_range(0, 99) >= 16);
            end
        end
    end

    // monitor: predict on input transfers, check output transfers, watchdog
    always @(posedge aclk) begin : watch
        res_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                decode_body_byte(s_tdata, s_tlast);
                body_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: out_byte %h status %0d out_last %b",
                           m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.data) begin
                        $error("out_byte: expected %h, got %h", want.data, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("out_last: expected %b, got %b", want.last, m_tlast);
                        errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule

>>> filelist.f
sv/esd_pkg.sv
sv/esd_front.sv
sv/esd_fifo.sv
sv/esd_back.sv
sv/escape_sequence_decoder.sv
test/escape_sequence_decoder_tb.sv
